@@ hw/rtl/triangle_point_barycentric_assert.svh @@
// ----------------------------------------------------------------------------
// triangle_point_barycentric assertion macros
// Shared property templates for the checker of the point-in-triangle block.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_POINT_BARYCENTRIC_ASSERT_SVH
`define TRIANGLE_POINT_BARYCENTRIC_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TPB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/tpb_pkg.sv @@
// ----------------------------------------------------------------------------
// tpb_pkg
// Shared constants, types and width helpers of the barycentric triangle test.
// ----------------------------------------------------------------------------
package tpb_pkg;

	localparam int COORD_WIDTH_DEF  = 32;
	localparam int WEIGHT_FRAC_DEF  = 30;
	localparam int TOL_W            = 32;
	localparam int OUT_W            = 31;
	localparam logic [TOL_W-1:0] TOL_RESET = 32'd1;

	// operand slice of the split multipliers
	localparam int MUL_LIMB         = 34;

	// register stages of the front part, accept to queue write
	localparam int FRONT_STAGES     = 8;
	// power of two, deeper than the front pipeline
	localparam int QUEUE_DEPTH      = 16;
	// accept to result strobe, plus the weight bits
	localparam int LAT_BASE         = FRONT_STAGES + 3;

	typedef struct packed {
		logic in_tri;
		logic degen;
	} cls_t;

	// width of den, nu and nv for a given coordinate width
	function automatic int den_width(input int cw);
		return 4 * cw + 9;
	endfunction

endpackage

@@ hw/rtl/triangle_point_barycentric.sv @@
// Throughput: one transaction per cycle; the front is 8 stages, the back is a
//   divider with one quotient bit per stage, WEIGHT_FRAC_BITS + 1 stages.
// busy only rises if the queue between front and back could overflow, which
//   the non-stalling result side never lets happen.
// Reset: arst_n clears all control state and sets the plane tolerance tol_q to 1.
// ----------------------------------------------------------------------------
// triangle_point_barycentric
// 3D point-in-triangle test with barycentric weights u and v in fixed point.
// ----------------------------------------------------------------------------
module triangle_point_barycentric import tpb_pkg::*; #(
	parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
	parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cfg_wr_en,
	input  logic [TOL_W-1:0]              cfg_wr_data,
	input  logic signed [COORD_WIDTH-1:0] vertex_a_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_a_y,
	input  logic signed [COORD_WIDTH-1:0] vertex_a_z,
	input  logic signed [COORD_WIDTH-1:0] vertex_b_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_b_y,
	input  logic signed [COORD_WIDTH-1:0] vertex_b_z,
	input  logic signed [COORD_WIDTH-1:0] vertex_c_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_c_y,
	input  logic signed [COORD_WIDTH-1:0] vertex_c_z,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	output logic                          done,
	output logic                          inside_res,
	output logic [OUT_W-1:0]              u_coord,
	output logic [OUT_W-1:0]              v_coord,
	output logic                          degenerate
);

	localparam int DN   = den_width(COORD_WIDTH);
	localparam int QEW  = $bits(cls_t) + 3 * DN;
	localparam int IFW  = $clog2(FRONT_STAGES + 1);
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int SUMW = ((CNTW > IFW) ? CNTW : IFW) + 1;

	logic [TOL_W-1:0]           tol_q;
	logic                       accept;
	logic signed [COORD_WIDTH-1:0] crd [12];

	logic                       push;
	cls_t                       f_cls;
	logic [DN-1:0]              f_nu;
	logic [DN-1:0]              f_nv;
	logic [DN-1:0]              f_den;
	logic [IFW-1:0]             inflight;

	logic [QEW-1:0]             q_wdata;
	logic [QEW-1:0]             q_rdata;
	logic [CNTW-1:0]            q_count;
	logic                       pop;

	cls_t                       b_cls;
	logic [DN-1:0]              b_nu;
	logic [DN-1:0]              b_nv;
	logic [DN-1:0]              b_den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	// room for everything already in the front
	assign busy   = (SUMW'(q_count) + SUMW'(inflight)) >= SUMW'(QUEUE_DEPTH);
	assign accept = start && !busy;

	assign crd[0]  = vertex_a_x;
	assign crd[1]  = vertex_a_y;
	assign crd[2]  = vertex_a_z;
	assign crd[3]  = vertex_b_x;
	assign crd[4]  = vertex_b_y;
	assign crd[5]  = vertex_b_z;
	assign crd[6]  = vertex_c_x;
	assign crd[7]  = vertex_c_y;
	assign crd[8]  = vertex_c_z;
	assign crd[9]  = point_x;
	assign crd[10] = point_y;
	assign crd[11] = point_z;

	tpb_front #(.CW(COORD_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (accept),
		.crd      (crd),
		.tol      (tol_q),
		.push     (push),
		.cls      (f_cls),
		.nu       (f_nu),
		.nv       (f_nv),
		.den      (f_den),
		.inflight (inflight)
	);

	assign q_wdata = {f_cls, f_nu, f_nv, f_den};
	assign pop     = q_count != '0;

	tpb_queue #(.W(QEW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.pop    (pop),
		.rdata  (q_rdata),
		.count  (q_count)
	);

	assign {b_cls, b_nu, b_nv, b_den} = q_rdata;

	tpb_div #(.DN(DN), .WF(WEIGHT_FRAC_BITS)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld        (pop),
		.cls        (b_cls),
		.nu         (b_nu),
		.nv         (b_nv),
		.den        (b_den),
		.done       (done),
		.inside_res (inside_res),
		.u_coord    (u_coord),
		.v_coord    (v_coord),
		.degenerate (degenerate)
	);

endmodule

@@ hw/rtl/tpb_mul.sv @@
// ----------------------------------------------------------------------------
// tpb_mul
// Two-stage signed multiplier, operands cut into limbs, partial products
// registered, then summed.
// ----------------------------------------------------------------------------
module tpb_mul import tpb_pkg::*; #(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  logic                       clk,
	input  logic signed [AW-1:0]       a,
	input  logic signed [BW-1:0]       b,
	output logic signed [AW+BW-1:0]    p
);

	localparam int KA = (AW + MUL_LIMB - 1) / MUL_LIMB;
	localparam int KB = (BW + MUL_LIMB - 1) / MUL_LIMB;
	localparam int AX = KA * MUL_LIMB;
	localparam int BX = KB * MUL_LIMB;
	localparam int PW = AX + BX;
	localparam int PO = AW + BW;

	logic signed [AX-1:0]           ax;
	logic signed [BX-1:0]           bx;
	logic signed [MUL_LIMB:0]       la [KA];
	logic signed [MUL_LIMB:0]       lb [KB];
	logic signed [2*MUL_LIMB+1:0]   pp_q [KA][KB];
	logic signed [PW-1:0]           acc;

	assign ax = AX'(a);
	assign bx = BX'(b);

	// top limb keeps the sign, lower limbs are unsigned
	for (genvar i = 0; i < KA; i++) begin : g_la
		if (i == KA - 1) begin : g_top
			assign la[i] = {ax[i*MUL_LIMB+MUL_LIMB-1], ax[i*MUL_LIMB +: MUL_LIMB]};
		end else begin : g_low
			assign la[i] = {1'b0, ax[i*MUL_LIMB +: MUL_LIMB]};
		end
	end
	for (genvar j = 0; j < KB; j++) begin : g_lb
		if (j == KB - 1) begin : g_top
			assign lb[j] = {bx[j*MUL_LIMB+MUL_LIMB-1], bx[j*MUL_LIMB +: MUL_LIMB]};
		end else begin : g_low
			assign lb[j] = {1'b0, bx[j*MUL_LIMB +: MUL_LIMB]};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < KA; i++) begin
			for (int j = 0; j < KB; j++) begin
				pp_q[i][j] <= la[i] * lb[j];
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < KA; i++) begin
			for (int j = 0; j < KB; j++) begin
				acc = acc + (PW'(pp_q[i][j]) <<< (MUL_LIMB * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		p <= PO'(acc);
	end

endmodule

@@ hw/rtl/tpb_front.sv @@
// ----------------------------------------------------------------------------
// tpb_front
// Edge vectors, normal, dot products, plane test and range classification.
// Eight stages, one item per cycle, no stall.
// ----------------------------------------------------------------------------
module tpb_front import tpb_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   acc,
	input  logic signed [CW-1:0]                   crd [12],
	input  logic [TOL_W-1:0]                       tol,
	output logic                                   push,
	output cls_t                                   cls,
	output logic [den_width(CW)-1:0]               nu,
	output logic [den_width(CW)-1:0]               nv,
	output logic [den_width(CW)-1:0]               den,
	output logic [$clog2(FRONT_STAGES+1)-1:0]      inflight
);

	localparam int E   = CW + 1;
	localparam int N   = 2 * E + 1;
	localparam int DT  = 2 * E + 2;
	localparam int DN  = den_width(CW);
	localparam int DW  = N + E + 2;
	localparam int CF  = CW / 2;
	localparam int IFW = $clog2(FRONT_STAGES + 1);

	logic [FRONT_STAGES-1:0]  vld_q;

	logic signed [E-1:0]      ab_s1 [3];
	logic signed [E-1:0]      ac_s1 [3];
	logic signed [E-1:0]      ap_s1 [3];
	logic signed [E-1:0]      ap_s2 [3];
	logic signed [E-1:0]      ap_s3 [3];
	logic signed [E-1:0]      ap_s4 [3];

	logic signed [E-1:0]      xa [6];
	logic signed [E-1:0]      xb [6];
	logic signed [2*E-1:0]    xp [6];
	logic signed [E-1:0]      da [5][3];
	logic signed [E-1:0]      db [5][3];
	logic signed [2*E-1:0]    dp [5][3];

	logic signed [N-1:0]      n_s4 [3];
	logic signed [DT-1:0]     dot_s4 [5];

	logic signed [N+E-1:0]    dterm [3];
	logic signed [DT-1:0]     pa [6];
	logic signed [DT-1:0]     pb [6];
	logic signed [2*DT-1:0]   wp [6];

	logic signed [DW-1:0]     d_s7;
	logic signed [DN-1:0]     den_s7;
	logic signed [DN-1:0]     nu_s7;
	logic signed [DN-1:0]     nv_s7;

	logic [DW-1:0]            dabs;
	logic [DW-1:0]            dsh;
	logic signed [DN:0]       sum_uv;
	logic                     off_plane;
	logic                     is_degen;
	logic                     nu_bad;
	logic                     nv_bad;
	logic                     hit;

	cls_t                     cls_s8;
	logic [DN-1:0]            nu_s8;
	logic [DN-1:0]            nv_s8;
	logic [DN-1:0]            den_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[FRONT_STAGES-2:0], acc};
		end
	end

	// s1: edge vectors from vertex a
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			ab_s1[k] <= E'(crd[3+k]) - E'(crd[k]);
			ac_s1[k] <= E'(crd[6+k]) - E'(crd[k]);
			ap_s1[k] <= E'(crd[9+k]) - E'(crd[k]);
		end
	end

	always_ff @(posedge clk) begin
		ap_s2 <= ap_s1;
		ap_s3 <= ap_s2;
		ap_s4 <= ap_s3;
	end

	// cross product terms of ab x ac
	assign xa[0] = ab_s1[1];  assign xb[0] = ac_s1[2];
	assign xa[1] = ab_s1[2];  assign xb[1] = ac_s1[1];
	assign xa[2] = ab_s1[2];  assign xb[2] = ac_s1[0];
	assign xa[3] = ab_s1[0];  assign xb[3] = ac_s1[2];
	assign xa[4] = ab_s1[0];  assign xb[4] = ac_s1[1];
	assign xa[5] = ab_s1[1];  assign xb[5] = ac_s1[0];

	// dots: ac.ac, ab.ab, ac.ab, ac.ap, ab.ap
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			da[0][k] = ac_s1[k];  db[0][k] = ac_s1[k];
			da[1][k] = ab_s1[k];  db[1][k] = ab_s1[k];
			da[2][k] = ac_s1[k];  db[2][k] = ab_s1[k];
			da[3][k] = ac_s1[k];  db[3][k] = ap_s1[k];
			da[4][k] = ab_s1[k];  db[4][k] = ap_s1[k];
		end
	end

	for (genvar g = 0; g < 6; g++) begin : g_xmul
		tpb_mul #(.AW(E), .BW(E)) u_mul (.clk(clk), .a(xa[g]), .b(xb[g]), .p(xp[g]));
	end

	for (genvar m = 0; m < 5; m++) begin : g_dmul
		for (genvar k = 0; k < 3; k++) begin : g_term
			tpb_mul #(.AW(E), .BW(E)) u_mul (
				.clk(clk), .a(da[m][k]), .b(db[m][k]), .p(dp[m][k])
			);
		end
	end

	// s4: normal and dot sums
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			n_s4[k] <= N'(xp[2*k]) - N'(xp[2*k+1]);
		end
		for (int m = 0; m < 5; m++) begin
			dot_s4[m] <= DT'(dp[m][0]) + DT'(dp[m][1]) + DT'(dp[m][2]);
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_nmul
		tpb_mul #(.AW(N), .BW(E)) u_mul (.clk(clk), .a(n_s4[k]), .b(ap_s4[k]), .p(dterm[k]));
	end

	// den = aa*ab2 - x*x, nu = ab2*cp - x*bp, nv = aa*bp - x*cp
	assign pa[0] = dot_s4[0];  assign pb[0] = dot_s4[1];
	assign pa[1] = dot_s4[2];  assign pb[1] = dot_s4[2];
	assign pa[2] = dot_s4[1];  assign pb[2] = dot_s4[3];
	assign pa[3] = dot_s4[2];  assign pb[3] = dot_s4[4];
	assign pa[4] = dot_s4[0];  assign pb[4] = dot_s4[4];
	assign pa[5] = dot_s4[2];  assign pb[5] = dot_s4[3];

	for (genvar g = 0; g < 6; g++) begin : g_wmul
		tpb_mul #(.AW(DT), .BW(DT)) u_mul (.clk(clk), .a(pa[g]), .b(pb[g]), .p(wp[g]));
	end

	// s7
	always_ff @(posedge clk) begin
		d_s7   <= DW'(dterm[0]) + DW'(dterm[1]) + DW'(dterm[2]);
		den_s7 <= DN'(wp[0]) - DN'(wp[1]);
		nu_s7  <= DN'(wp[2]) - DN'(wp[3]);
		nv_s7  <= DN'(wp[4]) - DN'(wp[5]);
	end

	always_comb begin
		dabs      = d_s7[DW-1] ? DW'(-d_s7) : DW'(d_s7);
		dsh       = dabs >> (2 * CF);
		off_plane = dsh > DW'(tol);
		is_degen  = den_s7 == '0;
		nu_bad    = nu_s7[DN-1] || (nu_s7 > den_s7);
		sum_uv    = (DN+1)'(nu_s7) + (DN+1)'(nv_s7);
		nv_bad    = nv_s7[DN-1] || (sum_uv > (DN+1)'(den_s7));
		hit       = !off_plane && !is_degen && !nu_bad && !nv_bad;
	end

	// s8: classified item, numerators cleared on a miss
	always_ff @(posedge clk) begin
		cls_s8.in_tri <= hit;
		cls_s8.degen  <= !off_plane && is_degen;
		nu_s8         <= hit ? DN'(nu_s7) : '0;
		nv_s8         <= hit ? DN'(nv_s7) : '0;
		den_s8        <= DN'(den_s7);
	end

	always_comb begin
		inflight = '0;
		for (int i = 0; i < FRONT_STAGES; i++) begin
			inflight = inflight + IFW'(vld_q[i]);
		end
	end

	assign push = vld_q[FRONT_STAGES-1];
	assign cls  = cls_s8;
	assign nu   = nu_s8;
	assign nv   = nv_s8;
	assign den  = den_s8;

endmodule

@@ hw/rtl/tpb_queue.sv @@
// ----------------------------------------------------------------------------
// tpb_queue
// Small register queue between the classifying front and the divider back.
// ----------------------------------------------------------------------------
module tpb_queue import tpb_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [W-1:0]                   wdata,
	input  logic                           pop,
	output logic [W-1:0]                   rdata,
	output logic [$clog2(DEPTH+1)-1:0]     count
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]   mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign rdata = mem_q[rd_q];
	assign count = cnt_q;

endmodule

@@ hw/rtl/tpb_div.sv @@
// ----------------------------------------------------------------------------
// tpb_div
// Back part: two restoring dividers in lockstep, one quotient bit per stage,
// giving u = nu * 2^WF / den and v = nv * 2^WF / den, then the result register.
// ----------------------------------------------------------------------------
module tpb_div import tpb_pkg::*; #(
	parameter int DN = 137,
	parameter int WF = WEIGHT_FRAC_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld,
	input  cls_t               cls,
	input  logic [DN-1:0]      nu,
	input  logic [DN-1:0]      nv,
	input  logic [DN-1:0]      den,
	output logic               done,
	output logic               inside_res,
	output logic [OUT_W-1:0]   u_coord,
	output logic [OUT_W-1:0]   v_coord,
	output logic               degenerate
);

	localparam int QW = WF + 1;

	logic [DN-1:0]  ru_i [QW];
	logic [DN-1:0]  rv_i [QW];
	logic [DN-1:0]  ru_x [QW];
	logic [DN-1:0]  rv_x [QW];
	logic [DN-1:0]  dn_i [QW];
	logic [QW-1:0]  qu_i [QW];
	logic [QW-1:0]  qv_i [QW];
	cls_t           cl_i [QW];
	logic [QW-1:0]  vl_i;
	logic [QW-1:0]  ge_u;
	logic [QW-1:0]  ge_v;

	logic [DN-1:0]  ru_s [QW];
	logic [DN-1:0]  rv_s [QW];
	logic [DN-1:0]  dn_s [QW];
	logic [QW-1:0]  qu_s [QW];
	logic [QW-1:0]  qv_s [QW];
	cls_t           cl_s [QW];
	logic [QW-1:0]  vld_s;

	logic               done_q;
	logic               inside_q;
	logic               degen_q;
	logic [OUT_W-1:0]   u_q;
	logic [OUT_W-1:0]   v_q;

	for (genvar j = 0; j < QW; j++) begin : g_stage
		if (j == 0) begin : g_first
			assign ru_i[j] = nu;
			assign rv_i[j] = nv;
			assign dn_i[j] = den;
			assign qu_i[j] = '0;
			assign qv_i[j] = '0;
			assign cl_i[j] = cls;
			assign vl_i[j] = vld;
			// integer bit of the weight: remainder starts below or at den
			assign ru_x[j] = ru_i[j];
			assign rv_x[j] = rv_i[j];
		end else begin : g_next
			assign ru_i[j] = ru_s[j-1];
			assign rv_i[j] = rv_s[j-1];
			assign dn_i[j] = dn_s[j-1];
			assign qu_i[j] = qu_s[j-1];
			assign qv_i[j] = qv_s[j-1];
			assign cl_i[j] = cl_s[j-1];
			assign vl_i[j] = vld_s[j-1];
			assign ru_x[j] = ru_i[j] << 1;
			assign rv_x[j] = rv_i[j] << 1;
		end

		assign ge_u[j] = ru_x[j] >= dn_i[j];
		assign ge_v[j] = rv_x[j] >= dn_i[j];

		always_ff @(posedge clk) begin
			ru_s[j] <= ge_u[j] ? ru_x[j] - dn_i[j] : ru_x[j];
			rv_s[j] <= ge_v[j] ? rv_x[j] - dn_i[j] : rv_x[j];
			qu_s[j] <= {qu_i[j][QW-2:0], ge_u[j]};
			qv_s[j] <= {qv_i[j][QW-2:0], ge_v[j]};
			dn_s[j] <= dn_i[j];
			cl_s[j] <= cl_i[j];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= vl_i[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[QW-1];
		end
	end

	// a miss or a degenerate triangle reads as zero weights
	always_ff @(posedge clk) begin
		inside_q <= cl_s[QW-1].in_tri;
		degen_q  <= cl_s[QW-1].degen;
		u_q      <= cl_s[QW-1].in_tri ? OUT_W'(qu_s[QW-1]) : '0;
		v_q      <= cl_s[QW-1].in_tri ? OUT_W'(qv_s[QW-1]) : '0;
	end

	assign done       = done_q;
	assign inside_res = inside_q;
	assign degenerate = degen_q;
	assign u_coord    = u_q;
	assign v_coord    = v_q;

endmodule

@@ hw/rtl/tpb_checker.sv @@
// ----------------------------------------------------------------------------
// tpb_checker
// Port-level checks of the barycentric block, bound to the top level.
// ----------------------------------------------------------------------------
module tpb_checker import tpb_pkg::*; #(
	parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               inside_res,
	input logic [OUT_W-1:0]   u_coord,
	input logic [OUT_W-1:0]   v_coord,
	input logic               degenerate
);

	localparam int LAT = LAT_BASE + WEIGHT_FRAC_BITS;

`include "triangle_point_barycentric_assert.svh"

	`TPB_ASSERT_IMP(a_lat_fwd, start && !busy, ##LAT done, "transaction result missing")
	`TPB_ASSERT_IMP(a_lat_back, done, $past(start && !busy, LAT), "result without transaction")
	`TPB_ASSERT_IMP(a_miss_zero, done && !inside_res, u_coord == '0 && v_coord == '0, "weights on miss")
	`TPB_ASSERT_IMP(a_hit_nondeg, done && inside_res, !degenerate, "hit on degenerate triangle")
	`TPB_ASSERT_NEXT(a_no_busy, 1'b1, !busy, "queue backed up")

endmodule

bind triangle_point_barycentric tpb_checker #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_chk (.*);
